@@ src/bdp_pkg.sv @@
package bdp_pkg;

   localparam int WORD_W      = 64;
   localparam int MAG_W       = 63;
   localparam int SIZE_W      = 48;
   localparam int BYTE_W      = 8;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 64;

   localparam logic [OP_W-1:0] OP_CTRL  = 2'd0;
   localparam logic [OP_W-1:0] OP_DIFF  = 2'd1;
   localparam logic [OP_W-1:0] OP_EXTRA = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_RUN       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_ERR_ORDER = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_ERR_LEN   = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_NEW_SIZE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OLD_SIZE = 8'd1;

   typedef enum logic [2:0] {
      PH_CTRL,
      PH_DIFF,
      PH_EXTRA,
      PH_DONE,
      PH_ERR_ORDER,
      PH_ERR_LEN
   } phase_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [WORD_W-1:0] diff_len_raw;
      logic [WORD_W-1:0] extra_len_raw;
      logic [WORD_W-1:0] seek_raw;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] old_byte;
   } item_type;

   typedef struct packed {
      logic              len_bad;
      logic [SIZE_W-1:0] diff_len;
      logic [SIZE_W-1:0] extra_len;
      logic [WORD_W-1:0] seek;
   } ctrl_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic                out_valid;
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   old_addr;
      logic [SIZE_W-1:0]   new_pos;
   } result_type;

endpackage

@@ src/bdp_channels.sv @@
interface bdp_req_if;
   logic                          valid;
   logic                          ready;
   logic [bdp_pkg::OP_W-1:0]      operation;
   logic [bdp_pkg::WORD_W-1:0]    diff_len_raw;
   logic [bdp_pkg::WORD_W-1:0]    extra_len_raw;
   logic [bdp_pkg::WORD_W-1:0]    seek_raw;
   logic [bdp_pkg::BYTE_W-1:0]    data_byte;
   logic [bdp_pkg::BYTE_W-1:0]    old_byte;

   modport source (output valid, operation, diff_len_raw, extra_len_raw, seek_raw,
                   data_byte, old_byte, input ready);
   modport sink (input valid, operation, diff_len_raw, extra_len_raw, seek_raw,
                 data_byte, old_byte, output ready);
endinterface

interface bdp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bdp_pkg::BYTE_W-1:0]        out_byte;
   logic                              out_valid;
   logic [bdp_pkg::STATUS_W-1:0]      status;
   logic signed [bdp_pkg::WORD_W-1:0] old_addr;
   logic [bdp_pkg::SIZE_W-1:0]        new_pos;

   modport source (output valid, out_byte, out_valid, status, old_addr, new_pos,
                   input ready);
   modport sink (input valid, out_byte, out_valid, status, old_addr, new_pos,
                 output ready);
endinterface

interface bdp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [bdp_pkg::CSR_INDEX_W-1:0]   index;
   logic [bdp_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/bdp_decode.sv @@
module bdp_decode (
   input  bdp_pkg::item_type                 item,
   input  logic [bdp_pkg::SIZE_W-1:0]        new_size,
   input  logic [bdp_pkg::SIZE_W-1:0]        new_position,
   output bdp_pkg::ctrl_type                 ctrl
);

   localparam int SW = bdp_pkg::SIZE_W;
   localparam int MW = bdp_pkg::MAG_W;
   localparam int WW = bdp_pkg::WORD_W;

   logic [MW-1:0] dmag;
   logic [MW-1:0] emag;
   logic [MW-1:0] smag;
   logic          d_neg;
   logic          e_neg;
   logic [SW-1:0] room;
   logic [SW:0]   len_sum;

   assign dmag = item.diff_len_raw[MW-1:0];
   assign emag = item.extra_len_raw[MW-1:0];
   assign smag = item.seek_raw[MW-1:0];

   // negative zero is a plain zero
   assign d_neg = item.diff_len_raw[WW-1] && (dmag != '0);
   assign e_neg = item.extra_len_raw[WW-1] && (emag != '0);

   assign room    = (new_size > new_position) ? (new_size - new_position) : '0;
   assign len_sum = {1'b0, dmag[SW-1:0]} + {1'b0, emag[SW-1:0]};

   always_comb begin
      ctrl.len_bad   = d_neg || e_neg || (|dmag[MW-1:SW]) || (|emag[MW-1:SW]) ||
                       (dmag[SW-1:0] > room) || (len_sum > {1'b0, room});
      ctrl.diff_len  = dmag[SW-1:0];
      ctrl.extra_len = emag[SW-1:0];
      ctrl.seek      = item.seek_raw[WW-1] ? (WW'(0) - {1'b0, smag}) : {1'b0, smag};
   end

endmodule

@@ src/bdp_state.sv @@
module bdp_state (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_fire,
   input  bdp_pkg::item_type                  item,
   input  logic                               rsp_take,
   input  logic                               csr_wr,
   input  logic [bdp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bdp_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                               result_valid,
   output bdp_pkg::result_type                result
);

   localparam int SW = bdp_pkg::SIZE_W;
   localparam int WW = bdp_pkg::WORD_W;

   bdp_pkg::phase_type  phase_ff, phase_in;
   logic [SW-1:0]       diff_left_ff, diff_left_in;
   logic [SW-1:0]       extra_left_ff, extra_left_in;
   logic [WW-1:0]       seek_ff, seek_in;
   logic [WW-1:0]       old_position_ff, old_position_in;
   logic [SW-1:0]       new_position_ff, new_position_in;
   logic [SW-1:0]       new_size_ff, new_size_in;
   logic [SW-1:0]       old_size_ff, old_size_in;
   logic                result_valid_ff, result_valid_in;
   bdp_pkg::result_type result_ff, result_in;

   bdp_pkg::ctrl_type   ctrl;
   logic [SW-1:0]       new_pos_inc;
   logic                old_in_range;
   logic [bdp_pkg::BYTE_W-1:0] old_eff;

   function automatic bdp_pkg::phase_type settle(input logic [SW-1:0] pos,
                                                 input logic [SW-1:0] size);
      return (pos >= size) ? bdp_pkg::PH_DONE : bdp_pkg::PH_CTRL;
   endfunction

   function automatic logic [bdp_pkg::STATUS_W-1:0] status_of(input bdp_pkg::phase_type ph);
      logic [bdp_pkg::STATUS_W-1:0] st;
      case (ph)
         bdp_pkg::PH_DONE:      st = bdp_pkg::STAT_DONE;
         bdp_pkg::PH_ERR_ORDER: st = bdp_pkg::STAT_ERR_ORDER;
         bdp_pkg::PH_ERR_LEN:   st = bdp_pkg::STAT_ERR_LEN;
         default:               st = bdp_pkg::STAT_RUN;
      endcase
      return st;
   endfunction

   bdp_decode u_decode (
      .item         (item),
      .new_size     (new_size_ff),
      .new_position (new_position_ff),
      .ctrl         (ctrl)
   );

   assign new_pos_inc  = new_position_ff + SW'(1);
   // negative positions and positions at or past the old size read as zero
   assign old_in_range = !old_position_ff[WW-1] && (old_position_ff[WW-2:SW] == '0) &&
                         (old_position_ff[SW-1:0] < old_size_ff);
   assign old_eff      = old_in_range ? item.old_byte : '0;

   always_comb begin
      phase_in        = phase_ff;
      diff_left_in    = diff_left_ff;
      extra_left_in   = extra_left_ff;
      seek_in         = seek_ff;
      old_position_in = old_position_ff;
      new_position_in = new_position_ff;
      new_size_in     = new_size_ff;
      old_size_in     = old_size_ff;
      result_in       = result_ff;
      result_valid_in = item_fire ? 1'b1 : (rsp_take ? 1'b0 : result_valid_ff);

      if (csr_wr) begin
         if (csr_index == bdp_pkg::CSR_NEW_SIZE) begin
            new_size_in = csr_data[SW-1:0];
         end else if (csr_index == bdp_pkg::CSR_OLD_SIZE) begin
            old_size_in = csr_data[SW-1:0];
         end
      end

      if (item_fire) begin
         result_in.out_byte  = '0;
         result_in.out_valid = 1'b0;
         case (phase_ff)
            bdp_pkg::PH_CTRL: begin
               if (item.operation != bdp_pkg::OP_CTRL) begin
                  phase_in = bdp_pkg::PH_ERR_ORDER;
               end else if (ctrl.len_bad) begin
                  phase_in = bdp_pkg::PH_ERR_LEN;
               end else begin
                  diff_left_in  = ctrl.diff_len;
                  extra_left_in = ctrl.extra_len;
                  seek_in       = ctrl.seek;
                  if (ctrl.diff_len != '0) begin
                     phase_in = bdp_pkg::PH_DIFF;
                  end else if (ctrl.extra_len != '0) begin
                     phase_in = bdp_pkg::PH_EXTRA;
                  end else begin
                     // empty triple: seek at once
                     old_position_in = old_position_ff + ctrl.seek;
                     phase_in        = settle(new_position_ff, new_size_ff);
                  end
               end
            end
            bdp_pkg::PH_DIFF: begin
               if (item.operation != bdp_pkg::OP_DIFF) begin
                  phase_in = bdp_pkg::PH_ERR_ORDER;
               end else begin
                  result_in.out_byte  = item.data_byte + old_eff;
                  result_in.out_valid = 1'b1;
                  new_position_in     = new_pos_inc;
                  diff_left_in        = diff_left_ff - SW'(1);
                  if (diff_left_ff != SW'(1)) begin
                     old_position_in = old_position_ff + WW'(1);
                  end else if (extra_left_ff != '0) begin
                     old_position_in = old_position_ff + WW'(1);
                     phase_in        = bdp_pkg::PH_EXTRA;
                  end else begin
                     old_position_in = old_position_ff + WW'(1) + seek_ff;
                     phase_in        = settle(new_pos_inc, new_size_ff);
                  end
               end
            end
            bdp_pkg::PH_EXTRA: begin
               if (item.operation != bdp_pkg::OP_EXTRA) begin
                  phase_in = bdp_pkg::PH_ERR_ORDER;
               end else begin
                  result_in.out_byte  = item.data_byte;
                  result_in.out_valid = 1'b1;
                  new_position_in     = new_pos_inc;
                  extra_left_in       = extra_left_ff - SW'(1);
                  if (extra_left_ff == SW'(1)) begin
                     old_position_in = old_position_ff + seek_ff;
                     phase_in        = settle(new_pos_inc, new_size_ff);
                  end
               end
            end
            default: begin
               // finished or error held: drop the item
            end
         endcase
         result_in.status   = status_of(phase_in);
         result_in.old_addr = old_position_in;
         result_in.new_pos  = new_position_in;
      end else if (csr_wr && (phase_ff inside {bdp_pkg::PH_CTRL, bdp_pkg::PH_DONE})) begin
         phase_in = settle(new_position_ff, new_size_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= bdp_pkg::PH_DONE;
         diff_left_ff    <= '0;
         extra_left_ff   <= '0;
         old_position_ff <= '0;
         new_position_ff <= '0;
         new_size_ff     <= '0;
         old_size_ff     <= '0;
         result_valid_ff <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         diff_left_ff    <= diff_left_in;
         extra_left_ff   <= extra_left_in;
         old_position_ff <= old_position_in;
         new_position_ff <= new_position_in;
         new_size_ff     <= new_size_in;
         old_size_ff     <= old_size_in;
         result_valid_ff <= result_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seek_ff   <= seek_in;
      result_ff <= result_in;
   end

   assign result_valid = result_valid_ff;
   assign result       = result_ff;

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == bdp_pkg::PH_ERR_ORDER || phase_ff == bdp_pkg::PH_ERR_LEN)
      |=> phase_ff == $past(phase_ff))
      else $error("held error phase changed");

   a_byte_not_in_error: assert property (@(posedge clock) disable iff (reset)
      result_valid_ff && result_ff.out_valid
      |-> (result_ff.status == bdp_pkg::STAT_RUN || result_ff.status == bdp_pkg::STAT_DONE))
      else $error("file byte delivered with error status");

   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      result_valid_ff && !result_ff.out_valid |-> result_ff.out_byte == '0)
      else $error("nonzero byte without out_valid");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      item_fire && ((phase_ff == bdp_pkg::PH_DIFF && item.operation == bdp_pkg::OP_DIFF) ||
                    (phase_ff == bdp_pkg::PH_EXTRA && item.operation == bdp_pkg::OP_EXTRA))
      |=> new_position_ff == $past(new_position_ff) + SW'(1))
      else $error("new position did not advance by one");

endmodule

@@ src/binary_diff_patch_apply_core.sv @@
// Applies a decompressed bsdiff40 patch stream to an old file one item at a time: control
// triples, diff bytes (added to the old byte at old_addr, zero outside the old file) and
// extra bytes. Every accepted item yields exactly one result item, and the block takes one
// item per clock cycle when the result side keeps up; each item passes through the
// input register and the result register. The rate is set by the per-item update of
// the patch state (phase, counters and positions) in the state stage. The old byte carried
// by a diff item must be the one at the old_addr reported by the previous result. The
// configuration port is always ready; write new_size and old_size only while no item is
// in flight.
module binary_diff_patch_apply_core (
   input  logic       clock,
   input  logic       reset,
   bdp_req_if.sink    req_if,
   bdp_rsp_if.source  rsp_if,
   bdp_csr_if.sink    csr_if
);

   logic                s1_valid_ff, s1_valid_in;
   bdp_pkg::item_type   s1_item_ff, s1_item_in;
   logic                advance;
   logic                item_fire;
   logic                req_take;
   logic                rsp_take;
   logic                result_valid;
   bdp_pkg::result_type result;

   assign advance   = !result_valid || rsp_if.ready;
   assign item_fire = s1_valid_ff && advance;
   assign req_take  = req_if.valid && req_if.ready;
   assign rsp_take  = rsp_if.valid && rsp_if.ready;

   assign req_if.ready = !s1_valid_ff || advance;
   assign csr_if.ready = 1'b1;

   always_comb begin
      s1_valid_in = req_take ? 1'b1 : (item_fire ? 1'b0 : s1_valid_ff);
      s1_item_in  = s1_item_ff;
      if (req_take) begin
         s1_item_in.operation     = req_if.operation;
         s1_item_in.diff_len_raw  = req_if.diff_len_raw;
         s1_item_in.extra_len_raw = req_if.extra_len_raw;
         s1_item_in.seek_raw      = req_if.seek_raw;
         s1_item_in.data_byte     = req_if.data_byte;
         s1_item_in.old_byte      = req_if.old_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
   end

   bdp_state u_state (
      .clock        (clock),
      .reset        (reset),
      .item_fire    (item_fire),
      .item         (s1_item_ff),
      .rsp_take     (rsp_take),
      .csr_wr       (csr_if.valid && csr_if.ready),
      .csr_index    (csr_if.index),
      .csr_data     (csr_if.data),
      .result_valid (result_valid),
      .result       (result)
   );

   assign rsp_if.valid     = result_valid;
   assign rsp_if.out_byte  = result.out_byte;
   assign rsp_if.out_valid = result.out_valid;
   assign rsp_if.status    = result.status;
   assign rsp_if.old_addr  = $signed(result.old_addr);
   assign rsp_if.new_pos   = result.new_pos;

endmodule

@@ sim/bdp_patch_checker.sv @@
`timescale 1ns / 1ps

module bdp_patch_checker
   import bdp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   bdp_req_if   req_mon,
   bdp_rsp_if   rsp_mon,
   bdp_csr_if   csr_mon,
   output int   fail_count,
   output int   pending
);

   localparam int PRINT_CAP = 40;

   // predicted patch state
   phase_type         ph;
   logic [63:0]       diff_rem;
   logic [63:0]       extra_rem;
   logic [63:0]       seek_hold;
   logic [63:0]       old_pos;
   logic [SIZE_W-1:0] built_pos;
   logic [SIZE_W-1:0] new_size_q;
   logic [SIZE_W-1:0] old_size_q;

   result_type rebuilt_q[$];
   int         fails = 0;
   int         in_flight = 0;

   assign fail_count = fails;
   assign pending    = in_flight;

   function automatic void settle_phase();
      ph = (built_pos >= new_size_q) ? PH_DONE : PH_CTRL;
   endfunction

   function automatic void close_triple();
      old_pos   = old_pos + seek_hold;
      seek_hold = '0;
      settle_phase();
   endfunction

   function automatic logic [63:0] seek_value(logic [63:0] raw);
      return raw[63] ? (64'd0 - {1'b0, raw[62:0]}) : {1'b0, raw[62:0]};
   endfunction

   // negative zero counts as zero
   function automatic logic len_negative(logic [63:0] raw);
      return raw[63] && (raw[62:0] != '0);
   endfunction

   function automatic void clear_patch_state();
      new_size_q = '0;
      old_size_q = '0;
      diff_rem   = '0;
      extra_rem  = '0;
      seek_hold  = '0;
      old_pos    = '0;
      built_pos  = '0;
      settle_phase();
   endfunction

   function automatic void write_size(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_NEW_SIZE) begin
         new_size_q = data[SIZE_W-1:0];
      end else if (idx == CSR_OLD_SIZE) begin
         old_size_q = data[SIZE_W-1:0];
      end else begin
         return;
      end
      if (ph == PH_CTRL || ph == PH_DONE) settle_phase();
   endfunction

   function automatic result_type apply_patch_item(item_type it);
      result_type  r;
      logic [63:0] dmag;
      logic [63:0] emag;
      logic [63:0] room;
      logic [7:0]  ob;
      r = '0;
      if (ph inside {PH_DONE, PH_ERR_ORDER, PH_ERR_LEN}) begin
         // hold: finished or sticky error
      end else if (it.operation == OP_CTRL && ph == PH_CTRL) begin
         dmag = {1'b0, it.diff_len_raw[62:0]};
         emag = {1'b0, it.extra_len_raw[62:0]};
         room = (new_size_q > built_pos) ? {16'd0, new_size_q - built_pos} : 64'd0;
         if (len_negative(it.diff_len_raw) || len_negative(it.extra_len_raw) ||
             dmag > room || emag > room - dmag) begin
            ph = PH_ERR_LEN;
         end else begin
            diff_rem  = dmag;
            extra_rem = emag;
            seek_hold = seek_value(it.seek_raw);
            if (diff_rem != 0) ph = PH_DIFF;
            else if (extra_rem != 0) ph = PH_EXTRA;
            else close_triple();
         end
      end else if (it.operation == OP_DIFF && ph == PH_DIFF) begin
         ob = (!old_pos[63] && old_pos < {16'd0, old_size_q}) ? it.old_byte : 8'd0;
         r.out_byte  = it.data_byte + ob;
         r.out_valid = 1'b1;
         old_pos     = old_pos + 64'd1;
         built_pos   = built_pos + 1'b1;
         diff_rem    = diff_rem - 64'd1;
         if (diff_rem == 0) begin
            if (extra_rem != 0) ph = PH_EXTRA;
            else close_triple();
         end
      end else if (it.operation == OP_EXTRA && ph == PH_EXTRA) begin
         r.out_byte  = it.data_byte;
         r.out_valid = 1'b1;
         built_pos   = built_pos + 1'b1;
         extra_rem   = extra_rem - 64'd1;
         if (extra_rem == 0) close_triple();
      end else begin
         ph = PH_ERR_ORDER;
      end
      case (ph)
         PH_DONE:      r.status = STAT_DONE;
         PH_ERR_ORDER: r.status = STAT_ERR_ORDER;
         PH_ERR_LEN:   r.status = STAT_ERR_LEN;
         default:      r.status = STAT_RUN;
      endcase
      r.old_addr = old_pos;
      r.new_pos  = built_pos;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      fails++;
      if (fails <= PRINT_CAP)
         $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
   endtask

   initial clear_patch_state();

   always @(posedge clock) begin : watch
      item_type   it;
      result_type got;
      result_type want;
      if (reset) begin
         clear_patch_state();
         rebuilt_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) write_size(csr_mon.index, csr_mon.data);
         if (req_mon.valid && req_mon.ready) begin
            it.operation     = req_mon.operation;
            it.diff_len_raw  = req_mon.diff_len_raw;
            it.extra_len_raw = req_mon.extra_len_raw;
            it.seek_raw      = req_mon.seek_raw;
            it.data_byte     = req_mon.data_byte;
            it.old_byte      = req_mon.old_byte;
            rebuilt_q.push_back(apply_patch_item(it));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.out_byte  = rsp_mon.out_byte;
            got.out_valid = rsp_mon.out_valid;
            got.status    = rsp_mon.status;
            got.old_addr  = rsp_mon.old_addr;
            got.new_pos   = rsp_mon.new_pos;
            if (rebuilt_q.size() == 0) begin
               report_mismatch("result with nothing expected", 64'(got.new_pos), 64'd0);
            end else begin
               want = rebuilt_q.pop_front();
               if (got.out_byte !== want.out_byte)
                  report_mismatch("out_byte", 64'(got.out_byte), 64'(want.out_byte));
               if (got.out_valid !== want.out_valid)
                  report_mismatch("out_valid", 64'(got.out_valid), 64'(want.out_valid));
               if (got.status !== want.status)
                  report_mismatch("status", 64'(got.status), 64'(want.status));
               if (got.old_addr !== want.old_addr)
                  report_mismatch("old_addr", got.old_addr, want.old_addr);
               if (got.new_pos !== want.new_pos)
                  report_mismatch("new_pos", 64'(got.new_pos), 64'(want.new_pos));
            end
         end
      end
      in_flight = rebuilt_q.size();
   end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import bdp_pkg::*;

   localparam int                     RANDOM_ITEMS = 1800;
   localparam int unsigned            CYCLE_LIMIT  = 600000;
   localparam logic [63:0]            NEG_ZERO     = 64'h8000_0000_0000_0000;
   localparam logic [63:0]            SEEK_MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0]            SEEK_MAX_NEG = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [OP_W-1:0]        OP_UNUSED    = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE    = 8'd2;

   logic clock = 1'b0;
   logic reset;
   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;
   int   fail_count;
   int   pending;

   int unsigned       cycles = 0;
   int                burst_left = 0;
   int                sent = 0;
   logic [SIZE_W-1:0] made_pos = '0;
   logic [63:0]       stim_old = '0;

   bdp_req_if req_if();
   bdp_rsp_if rsp_if();
   bdp_csr_if csr_if();

   binary_diff_patch_apply_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   bdp_patch_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .csr_mon    (csr_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      req_taken <= req_if.valid & req_if.ready;
      csr_taken <= csr_if.valid & csr_if.ready;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // result side: stall in changing patterns
   initial begin
      int mode;
      int left;
      int k;
      rsp_if.ready = 1'b0;
      mode = 0;
      left = 0;
      k = 2;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 4);
            left = $urandom_range(8, 120);
            k    = $urandom_range(2, 5);
         end
         left--;
         case (mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= 1'($urandom_range(0, 1));
            2:       rsp_if.ready <= (left % k) != 0;
            3:       rsp_if.ready <= (left % 16) < 2;
            default: rsp_if.ready <= $urandom_range(0, 7) != 0;
         endcase
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic item_type noise_fields();
      item_type it;
      it.operation     = 2'($urandom_range(0, 3));
      it.diff_len_raw  = {$urandom, $urandom};
      it.extra_len_raw = {$urandom, $urandom};
      it.seek_raw      = {$urandom, $urandom};
      it.data_byte     = pick_byte();
      it.old_byte      = pick_byte();
      return it;
   endfunction

   function automatic item_type ctrl_item(logic [63:0] d_raw, logic [63:0] e_raw,
                                          logic [63:0] s_raw);
      item_type it;
      it               = noise_fields();
      it.operation     = OP_CTRL;
      it.diff_len_raw  = d_raw;
      it.extra_len_raw = e_raw;
      it.seek_raw      = s_raw;
      return it;
   endfunction

   function automatic item_type byte_item(logic [OP_W-1:0] op);
      item_type it;
      it           = noise_fields();
      it.operation = op;
      return it;
   endfunction

   function automatic logic [63:0] seek_amount(logic [63:0] raw);
      return raw[63] ? (64'd0 - {1'b0, raw[62:0]}) : {1'b0, raw[62:0]};
   endfunction

   // mostly aim the old position just around the old file, now and then jump far
   function automatic logic [63:0] pick_seek(logic [63:0] from_pos);
      logic signed [63:0] target;
      logic signed [63:0] delta;
      case ($urandom_range(0, 9))
         0: return {$urandom, $urandom};
         1: return SEEK_MAX_POS;
         2: return SEEK_MAX_NEG;
         3: return NEG_ZERO;
         default: begin
            target = $signed(64'($urandom_range(0, 72))) - 64'sd3;
            delta  = target - $signed(from_pos);
            if (delta < 0) return {1'b1, 63'(-delta)};
            return {1'b0, delta[62:0]};
         end
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] pick_old_size();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return SIZE_W'($urandom_range(1, 64));
      endcase
   endfunction

   task automatic push(input item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_if.valid         <= 1'b1;
      req_if.operation     <= it.operation;
      req_if.diff_len_raw  <= it.diff_len_raw;
      req_if.extra_len_raw <= it.extra_len_raw;
      req_if.seek_raw      <= it.seek_raw;
      req_if.data_byte     <= it.data_byte;
      req_if.old_byte      <= it.old_byte;
      @(negedge clock);
      while (req_taken !== 1'b1) @(negedge clock);
   endtask

   // drop valid and wait until every result is back
   task automatic settle_block();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(negedge clock);
      while (csr_taken !== 1'b1) @(negedge clock);
      csr_if.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic triple(input logic [63:0] d_raw, e_raw, s_raw, input int d, e);
      push(ctrl_item(d_raw, e_raw, s_raw));
      repeat (d) push(byte_item(OP_DIFF));
      repeat (e) push(byte_item(OP_EXTRA));
      stim_old = stim_old + 64'(d) + seek_amount(s_raw);
      made_pos = made_pos + SIZE_W'(d + e);
      sent += 1 + d + e;
   endtask

   task automatic run_triples(input int len);
      int          rem;
      int          d;
      int          e;
      logic [63:0] d_raw;
      logic [63:0] e_raw;
      rem = len;
      while (rem != 0) begin
         if ($urandom_range(0, 15) == 0) d = rem;
         else d = $urandom_range(0, (rem > 12) ? 12 : rem);
         e = $urandom_range(0, (rem - d > 12) ? 12 : rem - d);
         d_raw = (d == 0 && $urandom_range(0, 1) == 1) ? NEG_ZERO : 64'(d);
         e_raw = (e == 0 && $urandom_range(0, 1) == 1) ? NEG_ZERO : 64'(e);
         triple(d_raw, e_raw, pick_seek(stim_old + 64'(d)), d, e);
         rem -= d + e;
         // retune the old file between triples while nothing is due
         if (rem != 0 && $urandom_range(0, 9) == 0) begin
            settle_block();
            csr_write(CSR_OLD_SIZE, {16'($urandom), pick_old_size()});
         end
      end
   endtask

   initial begin
      int pick;
      int len;
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.operation     = OP_CTRL;
      req_if.diff_len_raw  = '0;
      req_if.extra_len_raw = '0;
      req_if.seek_raw      = '0;
      req_if.data_byte     = '0;
      req_if.old_byte      = '0;
      csr_if.valid         = 1'b0;
      csr_if.index         = '0;
      csr_if.data          = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // new size zero after reset: everything is ignored
      push(ctrl_item(64'd1, 64'd1, 64'd0));
      push(byte_item(OP_DIFF));
      push(byte_item(OP_UNUSED));
      settle_block();

      csr_write(CSR_OLD_SIZE, 64'd4);
      csr_write(CSR_SPARE, {$urandom, $urandom});
      csr_write(CSR_NEW_SIZE, 64'd12);
      // last diff byte lands on old_size: reads as zero
      triple(64'd5, 64'd2, NEG_ZERO, 5, 2);
      // empty triple seeks at once, below zero
      triple(64'd0, 64'd0, {1'b1, 63'd7}, 0, 0);
      triple(64'd3, NEG_ZERO, 64'd0, 3, 0);
      // seek wraps into the negative half
      triple(64'd0, 64'd2, SEEK_MAX_POS, 0, 2);
      push(byte_item(OP_EXTRA));
      settle_block();

      csr_write(CSR_NEW_SIZE, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(CSR_OLD_SIZE, 64'h0000_FFFF_FFFF_FFFF);
      triple(64'd2, 64'd0, SEEK_MAX_NEG, 2, 0);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         settle_block();
         csr_write(CSR_OLD_SIZE, {16'($urandom), pick_old_size()});
         pick = $urandom_range(0, 19);
         if (pick == 0 && made_pos != 0) begin
            // new size below what is built: finished at once
            csr_write(CSR_NEW_SIZE,
                      {16'($urandom), SIZE_W'($urandom_range(0, int'(made_pos) - 1))});
            repeat ($urandom_range(1, 4)) push(noise_fields());
         end else begin
            if (pick == 1) len = 0;
            else if (pick == 2) len = $urandom_range(100, 200);
            else len = $urandom_range(1, 40);
            csr_write(CSR_NEW_SIZE, {16'($urandom), made_pos + SIZE_W'(len)});
            run_triples(len);
            repeat ($urandom_range(0, 3)) push(noise_fields());
         end
      end

      // one sticky error to close the run
      settle_block();
      csr_write(CSR_NEW_SIZE, {16'd0, made_pos + SIZE_W'(20)});
      case ($urandom_range(0, 9))
         0: push(ctrl_item({1'b1, 63'($urandom_range(1, 1000))}, 64'd0, 64'd0));
         1: push(ctrl_item(64'd2, {1'b1, 63'd1}, 64'd0));
         2: push(ctrl_item(64'd21, 64'd0, 64'd0));
         3: push(ctrl_item(64'd10, 64'd11, 64'd0));
         4: push(ctrl_item({2'b01, 62'({$urandom, $urandom})}, 64'd0, 64'd0));
         5: begin
            push(ctrl_item(64'd3, 64'd0, 64'd0));
            push(ctrl_item(64'd1, 64'd0, 64'd0));
         end
         6: begin
            push(ctrl_item(64'd2, 64'd2, 64'd0));
            push(byte_item(OP_EXTRA));
         end
         7: begin
            push(ctrl_item(64'd0, 64'd3, 64'd0));
            push(byte_item(OP_DIFF));
         end
         8: push(byte_item(OP_UNUSED));
         default: push(byte_item(OP_DIFF));
      endcase
      repeat (6) push(noise_fields());

      settle_block();
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

@@ binary_diff_patch_apply_core.f @@
src/bdp_pkg.sv
src/bdp_channels.sv
src/bdp_decode.sv
src/bdp_state.sv
src/binary_diff_patch_apply_core.sv
sim/bdp_patch_checker.sv
sim/tb_top.sv
